// ----- hw/rtl/cwsc_pkg.sv -----
`timescale 1ns / 1ps

package cwsc_pkg;

  // Field and state widths
  localparam int SEQ_BITS   = 16;
  localparam int FUNC_W     = 2;
  localparam int SAMPLE_W   = 24;
  localparam int WIN_W      = 6;
  localparam int SEGB_W     = 11;
  localparam int SSTH_W     = 16;
  localparam int RTO_W      = 27;
  localparam int RTT_W      = 25;
  localparam int CWND_W     = 7;
  localparam int BYTES_W    = CWND_W + SEGB_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  localparam int MAX_WINDOW_DEF = 32;

  localparam logic [CWND_W-1:0] CWND_MAX = CWND_W'(64);
  localparam logic [RTO_W-1:0]  RTO_MAX  = {RTO_W{1'b1}};

  // Event kinds
  localparam logic [FUNC_W-1:0] FUNC_START   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK     = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SEGMENTS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SEGMENTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_BYTES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SSTHRESH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT    = 3'd4;

  // Configuration reset values
  localparam logic [SEQ_BITS-1:0] TOTAL_RST     = SEQ_BITS'(1);
  localparam logic [WIN_W-1:0]    WINDOW_RST    = WIN_W'(32);
  localparam logic [SEGB_W-1:0]   SEGB_RST      = SEGB_W'(1460);
  localparam logic [SSTH_W-1:0]   SSTH_RST      = SSTH_W'(64000);
  localparam logic [RTO_W-1:0]    TIMEOUT_RST   = RTO_W'(2000000);

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic do_event;
    logic do_est;
    logic do_dev;
    logic do_rto;
    logic do_prep;
    logic do_emit;
  } cwsc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_rtt;
    logic row_last;
    logic out_free;
  } cwsc_status_t;

endpackage

// ----- hw/rtl/cwsc_ctrl.sv -----
`timescale 1ns / 1ps

module cwsc_ctrl
  import cwsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  cwsc_status_t status_i,
  output cwsc_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVENT = 3'd1;
  localparam logic [2:0] ST_EST   = 3'd2;
  localparam logic [2:0] ST_DEV   = 3'd3;
  localparam logic [2:0] ST_RTO   = 3'd4;
  localparam logic [2:0] ST_PREP  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EVENT;
        end
      end
      ST_EVENT: begin
        cmd_o.do_event = 1'b1;
        state_d        = status_i.need_rtt ? ST_EST : ST_PREP;
      end
      ST_EST: begin
        cmd_o.do_est = 1'b1;
        state_d      = ST_DEV;
      end
      ST_DEV: begin
        cmd_o.do_dev = 1'b1;
        state_d      = ST_RTO;
      end
      ST_RTO: begin
        cmd_o.do_rto = 1'b1;
        state_d      = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.do_prep = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        // advance one row whenever the output register is free
        if (status_i.out_free) begin
          cmd_o.do_emit = 1'b1;
          if (status_i.row_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/cwsc_datapath.sv -----
`timescale 1ns / 1ps

module cwsc_datapath
  import cwsc_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // event payload
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [SEQ_BITS-1:0]   ack_number_i,
  input  logic [SAMPLE_W-1:0]   rtt_sample_i,
  // control
  input  cwsc_cmd_t             cmd_i,
  output cwsc_status_t          status_o,
  // result register
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  send_valid_o,
  output logic [SEQ_BITS-1:0]   seq_number_o,
  output logic                  final_segment_o,
  output logic                  last_of_run_o,
  output logic [CWND_W-1:0]     cwnd_now_o,
  output logic [RTO_W-1:0]      rto_us_o,
  output logic                  done_res_o
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int EXT_W = SEQ_BITS + 1;

  // Configuration registers
  logic [SEQ_BITS-1:0] total_q;
  logic [WIN_W-1:0]    window_q;
  logic [SEGB_W-1:0]   segb_q;
  logic [SSTH_W-1:0]   init_ssth_q;
  logic [RTO_W-1:0]    init_rto_q;

  // Protocol state
  logic [SEQ_BITS-1:0] base_q, base_d;
  logic [SEQ_BITS-1:0] next_q, next_d;
  logic [CWND_W-1:0]   cwnd_q, cwnd_d;
  logic [SSTH_W-1:0]   ssth_q, ssth_d;
  logic [RTT_W-1:0]    est_q, est_d;
  logic [RTT_W-1:0]    dev_q, dev_d;
  logic [RTO_W-1:0]    rto_q, rto_d;
  logic [1:0]          dup_q, dup_d;

  // Latched event
  logic [FUNC_W-1:0]   func_q;
  logic [SEQ_BITS-1:0] ack_q;
  logic [SAMPLE_W-1:0] sample_q;

  // Run bookkeeping
  logic [CNT_W-1:0]    rem_q;
  logic                done_q;

  // Result register
  logic                out_valid_q;
  logic                send_valid_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic                fin_q;
  logic                last_q;
  logic [CWND_W-1:0]   cwnd_out_q;
  logic [RTO_W-1:0]    rto_out_q;
  logic                done_out_q;

  // Effective window and run limit
  logic [CWND_W-1:0] win;
  logic [CWND_W-1:0] lim;
  always_comb begin
    win = {1'b0, window_q};
    if (window_q == '0) begin
      win = CWND_W'(1);
    end else if ({1'b0, window_q} > CWND_W'(MAX_WINDOW)) begin
      win = CWND_W'(MAX_WINDOW);
    end
    lim = (cwnd_q < win) ? cwnd_q : win;
  end

  // Window growth and threshold arithmetic
  logic [BYTES_W-1:0] bytes;
  logic [CWND_W:0]    grown;
  logic               is_new_ack;
  logic               is_dup_ack;
  logic               grow;
  logic [2:0]         dup_inc;
  assign bytes      = BYTES_W'(cwnd_q) * BYTES_W'(segb_q);
  assign grown      = (bytes >= BYTES_W'(ssth_q)) ? ({1'b0, cwnd_q} + (CWND_W+1)'(1))
                                                   : {cwnd_q, 1'b0};
  assign is_new_ack = (ack_q == next_q) && (ack_q > base_q);
  assign is_dup_ack = (ack_q >= base_q) && (ack_q < next_q);
  assign grow       = is_new_ack && (cwnd_q <= win);
  assign dup_inc    = {1'b0, dup_q} + 3'd1;

  // RTT filter steps
  logic [RTT_W+3:0] est_sum;
  logic [RTT_W-1:0] diff;
  logic [RTT_W+2:0] dev_sum;
  logic [RTT_W+2:0] rto_sum;
  assign est_sum = (RTT_W+4)'({est_q, 3'b000}) - (RTT_W+4)'(est_q) + (RTT_W+4)'(sample_q);
  assign diff    = (RTT_W'(sample_q) >= est_q) ? RTT_W'(sample_q) - est_q
                                                : est_q - RTT_W'(sample_q);
  assign dev_sum = (RTT_W+3)'({dev_q, 1'b0}) + (RTT_W+3)'(dev_q) + (RTT_W+3)'(diff);
  assign rto_sum = (RTT_W+3)'(est_q) + (RTT_W+3)'({dev_q, 2'b00});

  // Run length for the prepare step
  logic [EXT_W-1:0] run_end;
  logic [EXT_W-1:0] avail_win;
  logic [EXT_W-1:0] avail_tot;
  logic [EXT_W-1:0] run_len;
  always_comb begin
    run_end   = {1'b0, base_q} + EXT_W'(lim);
    avail_win = ({1'b0, next_q} < run_end) ? run_end - {1'b0, next_q} : '0;
    avail_tot = (next_q < total_q) ? {1'b0, total_q} - {1'b0, next_q} : '0;
    run_len   = EXT_W'(lim);
    if (avail_win < run_len) begin
      run_len = avail_win;
    end
    if (avail_tot < run_len) begin
      run_len = avail_tot;
    end
  end

  // State update
  always_comb begin
    base_d = base_q;
    next_d = next_q;
    cwnd_d = cwnd_q;
    ssth_d = ssth_q;
    est_d  = est_q;
    dev_d  = dev_q;
    rto_d  = rto_q;
    dup_d  = dup_q;
    if (cmd_i.do_event) begin
      case (func_q)
        FUNC_START: begin
          base_d = '0;
          next_d = '0;
          cwnd_d = CWND_W'(1);
          ssth_d = init_ssth_q;
          est_d  = '0;
          dev_d  = '0;
          rto_d  = init_rto_q;
          dup_d  = '0;
        end
        FUNC_ACK: begin
          if (is_new_ack) begin
            if (grow) begin
              cwnd_d = (grown > {1'b0, CWND_MAX}) ? CWND_MAX : grown[CWND_W-1:0];
            end
            base_d = ack_q;
            next_d = ack_q;
            dup_d  = '0;
          end else if (is_dup_ack) begin
            base_d = ack_q;
            if (dup_inc >= 3'd3) begin
              next_d = ack_q;
              dup_d  = '0;
            end else begin
              dup_d = dup_inc[1:0];
            end
          end
        end
        FUNC_TIMEOUT: begin
          ssth_d = bytes[SSTH_W:1];
          cwnd_d = CWND_W'(1);
          rto_d  = (rto_q > (RTO_MAX >> 1)) ? RTO_MAX : {rto_q[RTO_W-2:0], 1'b0};
          next_d = base_q;
          dup_d  = '0;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.do_est) begin
      est_d = est_sum[RTT_W+2:3];
    end
    if (cmd_i.do_dev) begin
      dev_d = dev_sum[RTT_W+1:2];
    end
    if (cmd_i.do_rto) begin
      rto_d = (rto_sum > (RTT_W+3)'(RTO_MAX)) ? RTO_MAX : rto_sum[RTO_W-1:0];
    end
    if (cmd_i.do_emit && (rem_q != '0)) begin
      next_d = next_q + SEQ_BITS'(1);
    end
  end

  assign status_o.need_rtt = (func_q == FUNC_ACK) && grow;
  assign status_o.row_last = (rem_q <= CNT_W'(1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RST;
      window_q    <= WINDOW_RST;
      segb_q      <= SEGB_RST;
      init_ssth_q <= SSTH_RST;
      init_rto_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TOTAL_SEGMENTS:  total_q     <= cfg_data_i[SEQ_BITS-1:0];
        REG_WINDOW_SEGMENTS: window_q    <= cfg_data_i[WIN_W-1:0];
        REG_SEGMENT_BYTES:   segb_q      <= cfg_data_i[SEGB_W-1:0];
        REG_INIT_SSTHRESH:   init_ssth_q <= cfg_data_i[SSTH_W-1:0];
        REG_INIT_TIMEOUT:    init_rto_q  <= cfg_data_i[RTO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Protocol state and run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_q      <= '0;
      cwnd_q      <= CWND_W'(1);
      ssth_q      <= SSTH_RST;
      est_q       <= '0;
      dev_q       <= '0;
      rto_q       <= TIMEOUT_RST;
      dup_q       <= '0;
      rem_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      base_q <= base_d;
      next_q <= next_d;
      cwnd_q <= cwnd_d;
      ssth_q <= ssth_d;
      est_q  <= est_d;
      dev_q  <= dev_d;
      rto_q  <= rto_d;
      dup_q  <= dup_d;
      if (cmd_i.do_prep) begin
        rem_q  <= run_len[CNT_W-1:0];
        done_q <= (avail_tot <= run_len);
      end else if (cmd_i.do_emit && (rem_q != '0)) begin
        rem_q <= rem_q - CNT_W'(1);
      end
      if (cmd_i.do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q   <= func_i;
      ack_q    <= ack_number_i;
      sample_q <= rtt_sample_i;
    end
    if (cmd_i.do_emit) begin
      send_valid_q <= (rem_q != '0);
      seq_q        <= (rem_q != '0) ? next_q : '0;
      fin_q        <= (rem_q != '0) && (({1'b0, next_q} + EXT_W'(1)) == {1'b0, total_q});
      last_q       <= status_o.row_last;
      cwnd_out_q   <= cwnd_q;
      rto_out_q    <= rto_q;
      done_out_q   <= done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = send_valid_q;
  assign seq_number_o    = seq_q;
  assign final_segment_o = fin_q;
  assign last_of_run_o   = last_q;
  assign cwnd_now_o      = cwnd_out_q;
  assign rto_us_o        = rto_out_q;
  assign done_res_o      = done_out_q;

endmodule

// ----- hw/rtl/congestion_window_sender_control.sv -----
`timescale 1ns / 1ps
// Go-back-N sender controller with Reno-style window control and a
// Jacobson retransmission timeout.
// Slave stream: one event per request; tuser carries the event kind (start,
// ack, timeout), tdata carries the ack number and the RTT sample.
// Master stream: one request per segment allowed to go out, or a single
// request with tuser low when nothing may be sent; tlast marks the final
// request of the event. Every request carries the window, timeout and done
// flag as they stand after the event.
// Config channel: write the five registers by index while the block is idle.
// The first result request is registered through the event, prepare and
// emit steps after the event is accepted; an ack that updates the RTT filters
// also runs the estimate, deviation and timeout steps in turn before prepare.
// Throughput: one result per cycle while the output register is free; the
// sequencer walks the run one sequence number a cycle and pauses when the
// receiver stalls, and the event holds the block until its run ends. The next
// event is taken while the last result still waits in the output register.
// Reset: registers return to their defaults and the sender state to the
// state of a fresh transfer start. A stalled receiver holds the current
// result and the run simply pauses; no result is dropped.
module congestion_window_sender_control
  import cwsc_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // event stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [39:0]           s_axis_tdata,  // ack_number[15:0], rtt_sample_us[39:16]
  input  logic [FUNC_W-1:0]     s_axis_tuser,  // func[1:0]
  // segment stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,  // seq_number[15:0], final_segment[16],
                                               // cwnd_now[23:17], rto_us[50:24],
                                               // done_res[51], zero[55:52]
  output logic                  m_axis_tuser,  // send_valid[0]
  output logic                  m_axis_tlast,  // last_of_run
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cwsc_cmd_t    cmd;
  cwsc_status_t status;

  logic                send_valid;
  logic [SEQ_BITS-1:0] seq_number;
  logic                final_segment;
  logic [CWND_W-1:0]   cwnd_now;
  logic [RTO_W-1:0]    rto_us;
  logic                done_res;

  // Registers accept a write in any cycle
  assign cfg_ready_o = 1'b1;

  cwsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cwsc_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (s_axis_tuser),
    .ack_number_i    (s_axis_tdata[SEQ_BITS-1:0]),
    .rtt_sample_i    (s_axis_tdata[SEQ_BITS+SAMPLE_W-1:SEQ_BITS]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .send_valid_o    (send_valid),
    .seq_number_o    (seq_number),
    .final_segment_o (final_segment),
    .last_of_run_o   (m_axis_tlast),
    .cwnd_now_o      (cwnd_now),
    .rto_us_o        (rto_us),
    .done_res_o      (done_res)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {4'b0000, done_res, rto_us, cwnd_now, final_segment, seq_number};
  assign m_axis_tuser = send_valid;

endmodule
